// ----- rtl/hsc_pkg.sv -----
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types, constants and byte classification for the host name checker.
// ----------------------------------------------------------------------------
package hsc_pkg;

	localparam int unsigned NameLenW  = 8;
	localparam int unsigned LabelLenW = 7;
	localparam int unsigned CfgIdxW   = 2;
	localparam int unsigned CfgDataW  = 8;

	localparam logic [NameLenW-1:0]  NameLenMax  = '1;
	localparam logic [LabelLenW-1:0] LabelLenMax = '1;

	// Register reset values
	localparam logic [NameLenW-1:0]  MinNameLenRst  = 8'd3;
	localparam logic [NameLenW-1:0]  MaxNameLenRst  = 8'd253;
	localparam logic [LabelLenW-1:0] MaxLabelLenRst = 7'd63;

	// Special characters
	localparam logic [7:0] ChDot  = 8'h2e;
	localparam logic [7:0] ChDash = 8'h2d;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_MIN_NAME_LEN  = 2'd0,
		CFG_MAX_NAME_LEN  = 2'd1,
		CFG_MAX_LABEL_LEN = 2'd2
	} cfg_idx_t;

	// Length limits seen by the scanner
	typedef struct packed {
		logic [NameLenW-1:0]  min_name_len;
		logic [NameLenW-1:0]  max_name_len;
		logic [LabelLenW-1:0] max_label_len;
	} hsc_cfg_t;

	// Running state of the name being scanned
	typedef struct packed {
		logic [NameLenW-1:0]  total_count;
		logic [LabelLenW-1:0] label_count;
		logic                 at_label_start;
		logic                 prev_was_dash;
		logic                 letter_seen;
		logic                 dot_seen;
		logic                 rule_broken;
	} hsc_name_state_t;

	localparam hsc_name_state_t NameStateRst = '{
		total_count:    '0,
		label_count:    '0,
		at_label_start: 1'b1,
		prev_was_dash:  1'b0,
		letter_seen:    1'b0,
		dot_seen:       1'b0,
		rule_broken:    1'b0
	};

	// Character class of one byte
	typedef struct packed {
		logic is_letter;
		logic is_digit;
		logic is_dash;
		logic is_dot;
	} hsc_char_class_t;

	function automatic hsc_char_class_t hsc_classify(input logic [7:0] c);
		hsc_char_class_t cls;
		cls.is_letter = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
		cls.is_digit  = (c >= 8'h30 && c <= 8'h39);
		cls.is_dash   = (c == ChDash);
		cls.is_dot    = (c == ChDot);
		return cls;
	endfunction

endpackage

// ----- rtl/hostname_syntax_checker.sv -----
// ----------------------------------------------------------------------------
// hostname_syntax_checker
// Streams a host name one byte per beat and returns one pass/fail verdict.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, char_byte, is_last   | sink
//  out     | out_valid, out_ready, name_ok            | source
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| sink
//
//  One byte accepted per cycle unless a final byte is stalled; the verdict for
//  the final byte passes the input register, then the result register.
//  The rate is set by the state update between those registers, computed combinationally.
//  Reset clears the name state and loads the default length limits.
//  A stalled verdict holds the scan stage only on a final byte; other bytes
//  keep flowing. Config writes are always ready.
// ----------------------------------------------------------------------------
module hostname_syntax_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   char_byte,
	input  logic                         is_last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         name_ok,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hsc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [hsc_pkg::CfgDataW-1:0] cfg_data
);
	import hsc_pkg::*;

	hsc_cfg_t   cfg_q;
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       out_valid_q;
	logic       name_ok_q;
	logic       out_free;
	logic       adv_s1;
	logic       verdict_ok;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_name_len  <= MinNameLenRst;
			cfg_q.max_name_len  <= MaxNameLenRst;
			cfg_q.max_label_len <= MaxLabelLenRst;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN_NAME_LEN:  cfg_q.min_name_len  <= cfg_data;
				CFG_MAX_NAME_LEN:  cfg_q.max_name_len  <= cfg_data;
				CFG_MAX_LABEL_LEN: cfg_q.max_label_len <= cfg_data[LabelLenW-1:0];
				default: ;
			endcase
		end
	end

	// Flow control: only a final byte needs a free result slot
	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_byte;
			last_s1 <= is_last;
		end
	end

	hsc_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv_s1),
		.char_byte  (char_s1),
		.is_last    (last_s1),
		.cfg        (cfg_q),
		.verdict_ok (verdict_ok)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			name_ok_q <= verdict_ok;
		end
	end

	assign out_valid = out_valid_q;
	assign name_ok   = name_ok_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |-> !out_valid_q || out_ready)
		else $error("verdict written over a pending result");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && last_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked final beat");

endmodule

// ----- rtl/hsc_scan.sv -----
// ----------------------------------------------------------------------------
// hsc_scan
// Per-byte rule tracking and verdict for one host name at a time.
// ----------------------------------------------------------------------------
module hsc_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [7:0]                 char_byte,
	input  logic                       is_last,
	input  hsc_pkg::hsc_cfg_t          cfg,
	output logic                       verdict_ok
);
	import hsc_pkg::*;

	hsc_name_state_t st_q;
	hsc_name_state_t st_nxt;
	hsc_char_class_t cls;

	assign cls = hsc_classify(char_byte);

	// Next state after this byte
	always_comb begin
		st_nxt = st_q;
		if (st_q.total_count == NameLenMax) begin
			st_nxt.rule_broken = 1'b1;
		end else begin
			st_nxt.total_count = st_q.total_count + 8'd1;
		end
		if (cls.is_dot) begin
			if (st_q.at_label_start || st_q.prev_was_dash ||
			    (st_q.label_count > cfg.max_label_len)) begin
				st_nxt.rule_broken = 1'b1;
			end
			st_nxt.at_label_start = 1'b1;
			st_nxt.label_count    = '0;
			st_nxt.dot_seen       = 1'b1;
			st_nxt.prev_was_dash  = 1'b0;
		end else begin
			if (!(cls.is_letter || cls.is_digit || cls.is_dash)) begin
				st_nxt.rule_broken = 1'b1;
			end
			if (cls.is_letter) begin
				st_nxt.letter_seen = 1'b1;
			end
			// label may not open with a dash
			if (st_q.at_label_start && cls.is_dash) begin
				st_nxt.rule_broken = 1'b1;
			end
			st_nxt.at_label_start = 1'b0;
			if (st_q.label_count == LabelLenMax) begin
				st_nxt.rule_broken = 1'b1;
			end else begin
				st_nxt.label_count = st_q.label_count + 7'd1;
			end
			st_nxt.prev_was_dash = cls.is_dash;
		end
	end

	// Verdict on the final byte
	assign verdict_ok = !st_nxt.rule_broken
		&& (st_nxt.total_count >= cfg.min_name_len)
		&& (st_nxt.total_count <= cfg.max_name_len)
		&& st_nxt.dot_seen
		&& !st_nxt.at_label_start
		&& (st_nxt.label_count <= cfg.max_label_len)
		&& !st_nxt.prev_was_dash
		&& st_nxt.letter_seen;

	// State register, cleared after each name
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= NameStateRst;
		end else if (step) begin
			st_q <= is_last ? NameStateRst : st_nxt;
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_last |=> st_q == NameStateRst)
		else $error("name state not cleared after final beat");

	a_total_counts: assert property (@(posedge clk) disable iff (!arst_n)
		step && !is_last && (st_q.total_count != NameLenMax)
		|=> st_q.total_count == $past(st_q.total_count) + 8'd1)
		else $error("total count did not advance");

endmodule
